[sv/tcpc_pkg.sv]
`default_nettype none

package tcpc_pkg;

  // Default frame store geometry
  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned DEF_MAX_ROWS = 64;

  // Command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] REG_SCREEN_COLS = 8'd0;
  localparam logic [7:0] REG_SCREEN_ROWS = 8'd1;

  // Reset values
  localparam logic [7:0] SCREEN_COLS_RST = 8'd80;
  localparam logic [6:0] SCREEN_ROWS_RST = 7'd25;
  localparam logic [7:0] BLANK_GLYPH     = 8'h20;
  localparam logic [15:0] BLANK_COLOR    = 16'h0000;
  localparam logic [15:0] EMPTY_ORDER    = 16'hFFFF;

  // Input request
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] cell_col;
    logic signed [15:0] cell_row;
    logic [7:0]         glyph;
    logic [15:0]        color_attr;
    logic signed [15:0] draw_order;
  } req_t;

  // Read response
  typedef struct packed {
    logic [7:0]         read_glyph;
    logic [15:0]        read_color;
    logic signed [15:0] read_order;
    logic               read_in_range;
  } rsp_t;

  // Register write
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] data;
  } cfg_t;

  // One stored cell
  typedef struct packed {
    logic [7:0]  glyph;
    logic [15:0] color;
    logic [15:0] order;
  } cell_t;

  localparam cell_t BLANK_CELL = '{glyph: BLANK_GLYPH, color: BLANK_COLOR,
                                   order: EMPTY_ORDER};

endpackage

`default_nettype wire

[sv/tcpc_stream_if.sv]
`default_nettype none

interface tcpc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/text_cell_priority_compositor_unit.sv]
`default_nettype none

// Character-cell frame store with a draw order per cell, held in one synchronous
// RAM of MAX_COLS*MAX_ROWS words (glyph, color, order). A draw request that lands
// on screen reads the cell and writes it back next cycle if its order is not below
// the stored one; such a draw and a read request each make one RAM read, then the
// write-back or the loading of the response register. A draw dropped for its
// coordinates or a zero glyph, an unused command and a clear of an empty frame
// leave the frame unchanged and give no response. A read also waits in its access
// state while the previous response is still held. A clear request walks the
// visible frame one cell per cycle (sizes clipped to MAX_COLS and MAX_ROWS).
// After reset the RAM is swept to blank cells, during which no request is
// accepted; register writes are taken at any time. A response waiting in the
// output register does not block draw or clear requests.
module text_cell_priority_compositor_unit #(
  parameter int unsigned MAX_COLS = tcpc_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcpc_pkg::DEF_MAX_ROWS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tcpc_stream_if.sink   req_i,
  tcpc_stream_if.source rsp_o,
  tcpc_stream_if.sink   cfg_i
);

  import tcpc_pkg::*;

  localparam int unsigned CELLS  = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned VC_W   = $clog2(MAX_COLS + 1);
  localparam int unsigned VR_W   = $clog2(MAX_ROWS + 1);

  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [7:0]        screen_cols_q;
  logic [6:0]        screen_rows_q;
  logic [ADDR_W-1:0] init_addr_q;
  logic [COL_W-1:0]  clr_col_q;
  logic [ROW_W-1:0]  clr_row_q;
  logic [ADDR_W-1:0] clr_base_q;

  logic [1:0]         cmd_q;
  logic               hit_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [7:0]         glyph_q;
  logic [15:0]        color_q;
  logic signed [15:0] order_q;

  logic rsp_valid_q;
  rsp_t rsp_q;

  logic [VC_W-1:0]   vis_cols;
  logic [VR_W-1:0]   vis_rows;
  logic              on_screen;
  logic [ADDR_W-1:0] req_addr;
  logic              req_acc;
  req_t              req;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cell_t             ram_wdata;
  cell_t             rd_cell;
  logic              draw_wins;
  logic              clr_col_last;
  logic              clr_row_last;
  logic              rsp_free;

  assign req     = req_i.payload;
  assign req_acc = req_i.valid && req_i.ready;

  // Visible size, clipped to the store geometry
  assign vis_cols = (32'(screen_cols_q) > MAX_COLS) ? VC_W'(MAX_COLS) : VC_W'(screen_cols_q);
  assign vis_rows = (32'(screen_rows_q) > MAX_ROWS) ? VR_W'(MAX_ROWS) : VR_W'(screen_rows_q);

  // Bounds check and cell address of the request
  assign on_screen = !req.cell_col[15] && !req.cell_row[15]
                  && ($unsigned(req.cell_col) < 16'(vis_cols))
                  && ($unsigned(req.cell_row) < 16'(vis_rows));
  assign req_addr = ADDR_W'(req.cell_row[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                  + ADDR_W'(req.cell_col[COL_W-1:0]);

  // Handshakes
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;
  assign rsp_free      = !rsp_valid_q || rsp_o.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_cols_q <= SCREEN_COLS_RST;
      screen_rows_q <= SCREEN_ROWS_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.payload.index == REG_SCREEN_COLS) begin
        screen_cols_q <= cfg_i.payload.data;
      end else if (cfg_i.payload.index == REG_SCREEN_ROWS) begin
        screen_rows_q <= cfg_i.payload.data[6:0];
      end
    end
  end

  // Priority test on the cell read back
  assign draw_wins    = hit_q && ($signed(rd_cell.order) <= order_q);
  assign clr_col_last = VC_W'(clr_col_q) == (vis_cols - VC_W'(1));
  assign clr_row_last = VR_W'(clr_row_q) == (vis_rows - VR_W'(1));

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '{glyph: glyph_q, color: color_q, order: order_q};
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_addr_q;
        ram_wdata = BLANK_CELL;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_base_q + ADDR_W'(clr_col_q);
        ram_wdata = BLANK_CELL;
      end
      ST_ACCESS: begin
        ram_we = (cmd_q == CMD_DRAW) && draw_wins;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcpc_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELLS),
    .AW    (ADDR_W)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (req_acc),
    .raddr_i (req_addr),
    .rdata_o (rd_cell)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_addr_q == ADDR_W'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_acc) begin
          priority if (req.cmd == CMD_DRAW && req.glyph != 8'd0 && on_screen) begin
            state_d = ST_ACCESS;
          end else if (req.cmd == CMD_READ) begin
            state_d = ST_ACCESS;
          end else if (req.cmd == CMD_CLEAR && vis_cols != '0 && vis_rows != '0) begin
            state_d = ST_CLEAR;
          end else begin
            // dropped draw, empty clear or unused command
            state_d = ST_IDLE;
          end
        end
      end
      ST_ACCESS: begin
        if (cmd_q != CMD_READ || rsp_free) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_col_last && clr_row_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_addr_q <= '0;
      clr_col_q   <= '0;
      clr_row_q   <= '0;
      clr_base_q  <= '0;
      cmd_q       <= CMD_DRAW;
      hit_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        init_addr_q <= init_addr_q + ADDR_W'(1);
      end
      if (req_acc) begin
        cmd_q     <= req.cmd;
        hit_q     <= on_screen && (req.cmd != CMD_DRAW || req.glyph != 8'd0);
        clr_col_q <= '0;
        clr_row_q <= '0;
        clr_base_q <= '0;
      end else if (state_q == ST_CLEAR) begin
        if (clr_col_last) begin
          clr_col_q  <= '0;
          clr_row_q  <= clr_row_q + ROW_W'(1);
          clr_base_q <= clr_base_q + ADDR_W'(MAX_COLS);
        end else begin
          clr_col_q <= clr_col_q + COL_W'(1);
        end
      end
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      addr_q  <= req_addr;
      glyph_q <= req.glyph;
      color_q <= req.color_attr;
      order_q <= req.draw_order;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (state_q == ST_ACCESS && cmd_q == CMD_READ && rsp_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACCESS && cmd_q == CMD_READ && rsp_free) begin
      if (hit_q) begin
        rsp_q <= '{read_glyph: rd_cell.glyph, read_color: rd_cell.color,
                   read_order: rd_cell.order, read_in_range: 1'b1};
      end else begin
        rsp_q <= '0;
      end
    end
  end

  // Checks
  a_rsp_from_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == ST_ACCESS && $past(cmd_q) == CMD_READ)
    else $error("response loaded outside a read access");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != ST_IDLE)
    else $error("cell RAM written while idle");

  a_clear_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> VC_W'(clr_col_q) < vis_cols && VR_W'(clr_row_q) < vis_rows)
    else $error("clear walk left the visible frame");

  a_off_screen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_q.read_in_range |->
      rsp_q.read_glyph == '0 && rsp_q.read_color == '0 && rsp_q.read_order == '0)
    else $error("off-screen read returned nonzero fields");

endmodule

`default_nettype wire

[sv/tcpc_ram.sv]
`default_nettype none

module tcpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port; read data holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
